### sv/msb_pkg.sv
// Shared types and constants for the scaled byte matrix multiply.
package msb_pkg;

    localparam int ELEM_W = 8;
    localparam int PROD_W = 2 * ELEM_W;

    typedef logic [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last_k;
        logic last_entry;
    } msb_tag_t;

endpackage

### sv/matrix_multiply_scaled_byte.sv
// Scaled byte matrix multiply: loads A then B, emits low bytes of sum_k((A*B)>>8).
//
// Elements are taken one per cycle while busy is low: LEFT_ROWS*INNER_SIZE
// elements of A in row-major order, then INNER_SIZE*RIGHT_COLS elements of B.
// The request that carries the last element of B starts the compute, and busy
// stays high until the whole result matrix has been emitted. A single 8x8
// multiplier and accumulator do one product per cycle, limited by that one
// multiplier and the single read port of each matrix memory. Results appear in
// row-major order, each with result_valid high for exactly one cycle, and
// last_entry marks the final one; the receiver must take each result in the
// cycle that it is shown.
module matrix_multiply_scaled_byte #(
    parameter int LEFT_ROWS  = 64,
    parameter int INNER_SIZE = 8,
    parameter int RIGHT_COLS = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  msb_pkg::elem_t       element_value,
    output logic                 result_valid,
    output msb_pkg::elem_t       product_byte,
    output logic                 last_entry
);

    import msb_pkg::*;

    localparam int LEFT_SIZE  = LEFT_ROWS * INNER_SIZE;
    localparam int RIGHT_SIZE = INNER_SIZE * RIGHT_COLS;
    localparam int LOAD_TOTAL = LEFT_SIZE + RIGHT_SIZE;
    localparam int CW         = $clog2(LOAD_TOTAL + 1);
    localparam int LEFT_AW    = (LEFT_SIZE > 1) ? $clog2(LEFT_SIZE) : 1;
    localparam int RIGHT_AW   = (RIGHT_SIZE > 1) ? $clog2(RIGHT_SIZE) : 1;
    localparam int KW         = (INNER_SIZE > 1) ? $clog2(INNER_SIZE) : 1;
    localparam int IW         = (LEFT_ROWS > 1) ? $clog2(LEFT_ROWS) : 1;
    localparam int JW         = (RIGHT_COLS > 1) ? $clog2(RIGHT_COLS) : 1;

    localparam logic [1:0] ST_LOAD    = 2'd0;
    localparam logic [1:0] ST_COMPUTE = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;

    elem_t left_mem  [LEFT_SIZE];
    elem_t right_mem [RIGHT_SIZE];

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       load_count_reg, load_count_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [JW-1:0]       j_reg, j_next;
    logic [LEFT_AW-1:0]  a_addr_reg, a_addr_next;
    logic [LEFT_AW-1:0]  row_base_reg, row_base_next;
    logic [RIGHT_AW-1:0] b_addr_reg, b_addr_next;

    msb_tag_t            s1_reg, s2_reg, issue_tag;
    elem_t               a_data_reg, b_data_reg;
    elem_t               prod_reg;
    elem_t               acc_reg, acc_next;
    logic [PROD_W-1:0]   prod_full;

    logic                result_valid_reg;
    elem_t               product_byte_reg;
    logic                last_entry_reg;

    logic                accept;
    logic                to_left;
    logic                load_done;
    logic [CW-1:0]       right_off;
    logic                k_last, j_last, i_last;

    assign busy         = (state_reg != ST_LOAD);
    assign accept       = start && !busy;
    assign to_left      = (load_count_reg < CW'(LEFT_SIZE));
    assign right_off    = load_count_reg - CW'(LEFT_SIZE);
    assign load_done    = accept && (load_count_reg == CW'(LOAD_TOTAL - 1));

    assign k_last = (k_reg == KW'(INNER_SIZE - 1));
    assign j_last = (j_reg == JW'(RIGHT_COLS - 1));
    assign i_last = (i_reg == IW'(LEFT_ROWS - 1));

    always_ff @(posedge clk)
    begin
        if (accept && to_left)
        begin
            left_mem[load_count_reg[LEFT_AW-1:0]] <= element_value;
        end
        if (accept && !to_left)
        begin
            right_mem[right_off[RIGHT_AW-1:0]] <= element_value;
        end
    end

    always_ff @(posedge clk)
    begin
        a_data_reg <= left_mem[a_addr_reg];
        b_data_reg <= right_mem[b_addr_reg];
    end

    always_comb
    begin
        issue_tag.valid      = (state_reg == ST_COMPUTE);
        issue_tag.first      = (k_reg == '0);
        issue_tag.last_k     = k_last;
        issue_tag.last_entry = k_last && j_last && i_last;
    end

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        a_addr_next     = a_addr_reg;
        row_base_next   = row_base_reg;
        b_addr_next     = b_addr_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_done)
                begin
                    load_count_next = '0;
                    k_next          = '0;
                    i_next          = '0;
                    j_next          = '0;
                    a_addr_next     = '0;
                    row_base_next   = '0;
                    b_addr_next     = '0;
                    state_next      = ST_COMPUTE;
                end
                else if (accept)
                begin
                    load_count_next = load_count_reg + CW'(1);
                end
            end
            ST_COMPUTE:
            begin
                if (!k_last)
                begin
                    k_next      = k_reg + KW'(1);
                    a_addr_next = a_addr_reg + LEFT_AW'(1);
                    b_addr_next = b_addr_reg + RIGHT_AW'(RIGHT_COLS);
                end
                else if (!j_last)
                begin
                    k_next      = '0;
                    j_next      = j_reg + JW'(1);
                    a_addr_next = row_base_reg;
                    b_addr_next = RIGHT_AW'(j_reg) + RIGHT_AW'(1);
                end
                else
                begin
                    k_next        = '0;
                    j_next        = '0;
                    b_addr_next   = '0;
                    i_next        = i_reg + IW'(1);
                    row_base_next = row_base_reg + LEFT_AW'(INNER_SIZE);
                    a_addr_next   = row_base_reg + LEFT_AW'(INNER_SIZE);
                    if (i_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!s1_reg.valid && !s2_reg.valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            a_addr_reg     <= '0;
            row_base_reg   <= '0;
            b_addr_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            a_addr_reg     <= a_addr_next;
            row_base_reg   <= row_base_next;
            b_addr_reg     <= b_addr_next;
        end
    end

    assign prod_full = PROD_W'(a_data_reg) * PROD_W'(b_data_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[PROD_W-1:ELEM_W];
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_reg.valid)
        begin
            acc_next = (s2_reg.first ? '0 : acc_reg) + prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        product_byte_reg <= acc_next;
        last_entry_reg   <= s2_reg.last_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg           <= '0;
            s2_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg           <= issue_tag;
            s2_reg           <= s1_reg;
            result_valid_reg <= s2_reg.valid && s2_reg.last_k;
        end
    end

    assign result_valid = result_valid_reg;
    assign product_byte = product_byte_reg;
    assign last_entry   = last_entry_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !s1_reg.valid && !s2_reg.valid)
        else $error("Multiply pipeline is active while requests are taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("Result shown while the block is idle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_entry |-> state_reg == ST_DRAIN)
        else $error("Final entry emitted before the sequencer finished.");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_done |=> busy && state_reg == ST_COMPUTE)
        else $error("Compute did not start after the final element of B.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> !result_valid)
        else $error("Result strobe while loading.");

endmodule
